>>> rtl/hbsc_pkg.sv
// Package for the half/bfloat to single converter: format codes and constants.
// Used by the top level; depends on nothing.
`default_nettype none
package hbsc_pkg;
	localparam logic [1:0] FMT_HALF   = 2'd0;
	localparam logic [1:0] FMT_BF16   = 2'd1;
	localparam logic [1:0] FMT_SINGLE = 2'd2;
	localparam logic [1:0] FMT_NONE   = 2'd3;
	localparam logic [4:0] HALF_EXP_SPECIAL = 5'd31;
	localparam logic [7:0] HALF_REBIAS = 8'd112;
	localparam logic [7:0] SUB_BIAS = 8'd103;
	localparam logic [30:0] HALF_MAX_MAG = 31'h477FE000;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [31:0] word;
	} s1_t;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [31:0] word;
		logic [3:0]  lead;
	} s2_t;
endpackage
`default_nettype wire

>>> rtl/hbsc_stage.sv
// Pipeline control for one register stage: valid bit and stall handling.
// Depends on nothing; the top level chains three of them.
`default_nettype none
module hbsc_stage #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);
	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_data <= in_data;
		end
	end
endmodule
`default_nettype wire

>>> rtl/half_bfloat_to_single_convert_unit.sv
// Top level of the half/bfloat16/single to binary32 converter.
// Depends on hbsc_pkg and hbsc_stage.
`default_nettype none
// Three-stage pipeline, one word per cycle unless out_ready stalls. Stage one
// captures the word with the format, stage two finds the leading one of a half
// subnormal fraction, stage three assembles the binary32 pattern. Half
// infinity or NaN becomes +/-65504; format 3 yields +0.
module half_bfloat_to_single_convert_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] raw_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      single_bits
);
	logic [1:0] fmt_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {30'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= hbsc_pkg::FMT_HALF;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			fmt_q <= pwdata[1:0];
		end
	end

	hbsc_pkg::s1_t d1, q1;
	hbsc_pkg::s2_t d2, q2;
	logic [31:0] d3;
	logic v1, v2, r1, r2;

	assign d1.fmt = fmt_q;
	assign d1.word = raw_word;

	hbsc_stage #(.W($bits(hbsc_pkg::s1_t))) u_s1 (
		.clk, .arst_n, .in_valid, .in_ready, .in_data(d1),
		.out_valid(v1), .out_ready(r1), .out_data(q1));

	always_comb begin
		d2.fmt = q1.fmt;
		d2.word = q1.word;
		d2.lead = 4'd0;
		for (int k = 0; k < 10; k++) begin
			if (q1.word[k]) d2.lead = 4'(k);
		end
	end

	hbsc_stage #(.W($bits(hbsc_pkg::s2_t))) u_s2 (
		.clk, .arst_n, .in_valid(v1), .in_ready(r1), .in_data(d2),
		.out_valid(v2), .out_ready(r2), .out_data(q2));

	logic [4:0] ex;
	logic [9:0] fr;
	logic [22:0] sub_fr;
	assign ex = q2.word[14:10];
	assign fr = q2.word[9:0];
	assign sub_fr = 23'({fr, 13'd0} << (5'd10 - {1'b0, q2.lead}));

	always_comb begin
		case (q2.fmt)
			hbsc_pkg::FMT_HALF: begin
				if (ex == 5'd0) begin
					if (fr == 10'd0) d3 = {q2.word[15], 31'd0};
					else d3 = {q2.word[15], hbsc_pkg::SUB_BIAS + {4'd0, q2.lead}, sub_fr};
				end else if (ex == hbsc_pkg::HALF_EXP_SPECIAL) begin
					d3 = {q2.word[15], hbsc_pkg::HALF_MAX_MAG};
				end else begin
					d3 = {q2.word[15], hbsc_pkg::HALF_REBIAS + {3'd0, ex}, fr, 13'd0};
				end
			end
			hbsc_pkg::FMT_BF16:   d3 = {q2.word[15:0], 16'd0};
			hbsc_pkg::FMT_SINGLE: d3 = q2.word;
			default:              d3 = 32'd0;
		endcase
	end

	hbsc_stage #(.W(32)) u_s3 (
		.clk, .arst_n, .in_valid(v2), .in_ready(r2), .in_data(d3),
		.out_valid, .out_ready, .out_data(single_bits));

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(single_bits))
		else $error("result dropped under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v2 && r2 |=> out_valid)
		else $error("stage two word lost");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v1 |-> in_ready)
		else $error("input blocked with empty first stage");
`endif
endmodule
`default_nettype wire
